// ----- design/fipu_pkg.sv -----
// ----------------------------------------------------------------------------
// fipu_pkg: shared types and constants
// Operation codes, the request struct between sequencer and arithmetic unit,
// and the binary32 constants (one and the canonical quiet NaN) that they use.
// ----------------------------------------------------------------------------
package fipu_pkg;

  typedef enum logic {
    OP_MUL,
    OP_RECIP
  } op_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } req_t;

  localparam logic [31:0] ONE_BITS  = 32'h3F80_0000;
  localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;

endpackage

// ----- design/fipu_arith.sv -----
// ----------------------------------------------------------------------------
// fipu_arith: shared binary32 multiply / reciprocal unit
// Multiply a*b or form 1/b, round to nearest even, keep subnormals,
// infinities and a canonical quiet NaN. Multi-cycle, one operation at a time.
// ----------------------------------------------------------------------------
module fipu_arith (
  input  logic              clk,
  input  logic              rst,
  input  fipu_pkg::req_t    req,
  input  logic [31:0]       a,
  input  logic [31:0]       b,
  output logic              done,
  output logic [31:0]       res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_NORM,
    S_DNORM,
    S_DIV,
    S_DEND
  } state_t;

  state_t             state;
  logic               sgn;
  logic [23:0]        ma;
  logic [23:0]        mb;
  logic [47:0]        m;
  logic signed [10:0] e;
  logic [23:0]        rem;
  logic [23:0]        dvs;
  logic [47:0]        quo;
  logic [6:0]         cnt;

  logic               a_zero, a_inf, a_nan, b_zero, b_inf, b_nan;
  logic [23:0]        a_man, b_man;
  logic signed [10:0] a_e, b_e;

  assign a_zero = (a[30:0] == 31'd0);
  assign b_zero = (b[30:0] == 31'd0);
  assign a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
  assign b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
  assign a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
  assign b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
  assign a_man  = {(a[30:23] != 8'd0), a[22:0]};
  assign b_man  = {(b[30:23] != 8'd0), b[22:0]};
  assign a_e    = (a[30:23] == 8'd0) ? 11'sd1 : $signed({3'b000, a[30:23]});
  assign b_e    = (b[30:23] == 8'd0) ? 11'sd1 : $signed({3'b000, b[30:23]});

  // rounding of the normalized value m * 2^(e-174)
  logic signed [10:0] sh_full;
  logic [5:0]         sh;
  logic [111:0]       shifted;
  logic [47:0]        ms;
  logic               lost, g, st, inc, ovf;
  logic [7:0]         fbase;
  logic [24:0]        m25;
  logic [31:0]        sum;
  logic [31:0]        rnd_bits;

  always_comb begin
    sh_full = 11'sd1 - e;
    if (e >= 11'sd1) begin
      sh = 6'd0;
    end else if (sh_full > 11'sd63) begin
      sh = 6'd63;
    end else begin
      sh = sh_full[5:0];
    end
    shifted = {m, 64'd0} >> sh;
    ms      = shifted[111:64];
    lost    = |shifted[63:0];
    fbase   = (e >= 11'sd1) ? (e[7:0] - 8'd1) : 8'd0;
    g       = ms[23];
    st      = (|ms[22:0]) | lost;
    inc     = g & (st | ms[24]);
    m25     = {1'b0, ms[47:24]} + {24'd0, inc};
    sum     = {1'b0, fbase, 23'd0} + {7'd0, m25};
    ovf     = (e >= 11'sd255) || (sum >= 32'h7F80_0000);
    rnd_bits = ovf ? {sgn, 8'hFF, 23'd0} : {sgn, sum[30:0]};
  end

  logic [47:0] prod;
  logic [24:0] r2;

  assign prod = ma * mb;
  assign r2   = {rem, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.start) begin
            if (req.op == fipu_pkg::OP_MUL) begin
              sgn <= a[31] ^ b[31];
              if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf)) begin
                res  <= fipu_pkg::QNAN_BITS;
                done <= 1'b1;
              end else if (a_inf || b_inf) begin
                res  <= {a[31] ^ b[31], 8'hFF, 23'd0};
                done <= 1'b1;
              end else if (a_zero || b_zero) begin
                res  <= {a[31] ^ b[31], 31'd0};
                done <= 1'b1;
              end else begin
                ma    <= a_man;
                mb    <= b_man;
                e     <= a_e + b_e - 11'sd126;
                done  <= 1'b0;
                state <= S_MUL;
              end
            end else begin
              sgn <= b[31];
              if (b_nan) begin
                res  <= fipu_pkg::QNAN_BITS;
                done <= 1'b1;
              end else if (b_zero) begin
                res  <= {b[31], 8'hFF, 23'd0};
                done <= 1'b1;
              end else if (b_inf) begin
                res  <= {b[31], 31'd0};
                done <= 1'b1;
              end else begin
                m     <= {b_man, 24'd0};
                e     <= b_e;
                done  <= 1'b0;
                state <= S_DNORM;
              end
            end
          end else begin
            done <= 1'b0;
          end
        end
        S_MUL: begin
          done <= 1'b0;
          if (!prod[47] && (e > 11'sd1)) begin
            m <= {prod[46:0], 1'b0};
            e <= e - 11'sd1;
          end else begin
            m <= prod;
          end
          state <= S_NORM;
        end
        S_NORM: begin
          if (!m[47] && (e > 11'sd1)) begin
            m    <= {m[46:0], 1'b0};
            e    <= e - 11'sd1;
            done <= 1'b0;
          end else begin
            res   <= rnd_bits;
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_DNORM: begin
          done <= 1'b0;
          if (!m[47]) begin
            m <= {m[46:0], 1'b0};
            e <= e - 11'sd1;
          end else begin
            dvs   <= m[47:24];
            rem   <= 24'd1;
            quo   <= 48'd0;
            cnt   <= 7'd70;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          done <= 1'b0;
          if (r2 >= {1'b0, dvs}) begin
            rem <= 24'(r2 - {1'b0, dvs});
            quo <= {quo[46:0], 1'b1};
          end else begin
            rem <= r2[23:0];
            quo <= {quo[46:0], 1'b0};
          end
          cnt <= cnt - 7'd1;
          if (cnt == 7'd1) begin
            state <= S_DEND;
          end
        end
        S_DEND: begin
          done  <= 1'b0;
          m     <= {quo[47:1], quo[0] | (rem != 24'd0)};
          e     <= 11'sd254 - e;
          state <= S_NORM;
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- design/float_integer_power_unit.sv -----
// Sequencing: min(|exponent|, MAX_EXPONENT) multiplies on the arithmetic unit, preceded
// by a reciprocal when the exponent is negative; a zero or infinite operand is resolved
// directly in the arithmetic unit, and subnormal operands add normalization shifts.
// Exponent zero or a NaN base gives a valid result without using the arithmetic unit.
// Throughput: one item at a time; the next item is taken only after the result is loaded.
// Reset: synchronous, active high; clears the sequencer and output valid.
// ----------------------------------------------------------------------------
// float_integer_power_unit: binary32 base raised to a signed integer power
// Sequence repeated rounded multiplies (or by a rounded reciprocal) on one
// shared arithmetic unit.
// ----------------------------------------------------------------------------
module float_integer_power_unit #(
  parameter int MAX_EXPONENT = 255
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [31:0]       base_bits,
  input  logic signed [8:0] exponent,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       power_bits
);

  localparam int CW = $clog2(MAX_EXPONENT + 1);
  localparam fipu_pkg::req_t REQ_NONE = '{start: 1'b0, op: fipu_pkg::OP_MUL};

  typedef enum logic [1:0] {
    T_IDLE,
    T_RECIP,
    T_MUL,
    T_DONE
  } state_t;

  state_t         state;
  logic [CW-1:0]  cnt;
  logic [31:0]    factor;
  logic [31:0]    prod;
  fipu_pkg::req_t req;
  logic           done;
  logic [31:0]    res;

  logic [8:0]     mag;
  logic [CW-1:0]  mag_sat;
  logic           base_nan;

  assign mag      = exponent[8] ? 9'(-exponent) : exponent;
  assign mag_sat  = (32'(mag) > 32'(MAX_EXPONENT)) ? CW'(MAX_EXPONENT) : CW'(mag);
  assign base_nan = (base_bits[30:23] == 8'hFF) && (base_bits[22:0] != 23'd0);
  assign in_ready = (state == T_IDLE);

  fipu_arith u_arith (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .a    (prod),
    .b    (factor),
    .done (done),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      out_valid <= 1'b0;
      req       <= REQ_NONE;
    end else begin
      if ((state == T_DONE) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        T_IDLE: begin
          if (in_valid) begin
            cnt    <= mag_sat;
            factor <= base_bits;
            if (mag == 9'd0) begin
              prod  <= fipu_pkg::ONE_BITS;
              req   <= REQ_NONE;
              state <= T_DONE;
            end else if (base_nan) begin
              prod  <= fipu_pkg::QNAN_BITS;
              req   <= REQ_NONE;
              state <= T_DONE;
            end else if (exponent[8]) begin
              prod  <= fipu_pkg::ONE_BITS;
              req   <= '{start: 1'b1, op: fipu_pkg::OP_RECIP};
              state <= T_RECIP;
            end else begin
              prod  <= fipu_pkg::ONE_BITS;
              req   <= '{start: 1'b1, op: fipu_pkg::OP_MUL};
              state <= T_MUL;
            end
          end else begin
            req <= REQ_NONE;
          end
        end
        T_RECIP: begin
          if (done) begin
            factor <= res;
            req    <= '{start: 1'b1, op: fipu_pkg::OP_MUL};
            state  <= T_MUL;
          end else begin
            req <= REQ_NONE;
          end
        end
        T_MUL: begin
          if (done) begin
            prod <= res;
            if (cnt == CW'(1)) begin
              req   <= REQ_NONE;
              state <= T_DONE;
            end else begin
              cnt <= cnt - CW'(1);
              req <= '{start: 1'b1, op: fipu_pkg::OP_MUL};
            end
          end else begin
            req <= REQ_NONE;
          end
        end
        T_DONE: begin
          req <= REQ_NONE;
          if (!out_valid || out_ready) begin
            power_bits <= prod;
            state      <= T_IDLE;
          end
        end
        default: begin
          req   <= REQ_NONE;
          state <= T_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for float_integer_power_unit
// Sends binary32 bases with signed integer exponents, computes each power with
// a bit-exact software model of rounded repeated multiplication, and compares
// every result in order. Both sides idle at random, and the receiver holds off
// once for a long stretch so that the unit stalls its input.
// ----------------------------------------------------------------------------
module testbench;

  localparam int MAX_EXP     = 255;
  localparam int IDLE_LIMIT  = 20000;
  localparam int LONG_HOLD   = 700;
  localparam int RAND_ITEMS  = 1600;

  typedef struct {
    logic [31:0]       base;
    logic signed [8:0] expo;
  } power_item_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [31:0]       base_bits = '0;
  logic signed [8:0] exponent = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [31:0]       power_bits;

  power_item_t pending_items[$];
  logic [31:0] power_expected[$];
  int          errors = 0;
  int          results_seen = 0;
  int          items_sent = 0;
  int          idle_cycles = 0;
  int          send_gap = 0;
  int          recv_stall = 0;
  bit          took_in = 1'b0;
  bit          took_out = 1'b0;
  bit          long_hold_done = 1'b0;

  float_integer_power_unit #(.MAX_EXPONENT(MAX_EXP)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .base_bits(base_bits), .exponent(exponent),
    .out_valid(out_valid), .out_ready(out_ready),
    .power_bits(power_bits)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] widen_single(logic [31:0] b);
    logic [7:0]  e;
    logic [22:0] m;
    logic [63:0] sh;
    int          p;
    e = b[30:23];
    m = b[22:0];
    p = 0;
    if (e == 8'hFF) return {b[31], 11'h7FF, m, 29'b0};
    if (e == 8'h00) begin
      if (m == 0) return {b[31], 63'b0};
      for (int i = 0; i < 23; i++) if (m[i]) p = i;
      sh = 64'(m) << (52 - p);
      return {b[31], 11'(p + 874), sh[51:0]};
    end
    return {b[31], 11'(int'(e) + 896), m, 29'b0};
  endfunction

  function automatic logic [31:0] narrow_double(logic [63:0] d);
    logic [10:0] e;
    logic [63:0] sig, q, rem, half;
    int          ex, sh, fe;
    e = d[62:52];
    if (e == 11'h7FF) return (d[51:0] != 0) ? fipu_pkg::QNAN_BITS : {d[63], 8'hFF, 23'b0};
    if (e == 11'h000) return {d[63], 31'b0};
    sig = {11'b0, 1'b1, d[51:0]};
    ex = int'(e) - 1023;
    sh = (ex >= -126) ? 29 : 29 + (-126 - ex);
    if (sh > 60) sh = 60;
    q = sig >> sh;
    rem = sig & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q = q + 1;
    if (ex < -126) return {d[63], q[30:0]};
    fe = ex + 127;
    if (q[24]) begin
      q = q >> 1;
      fe++;
    end
    if (fe >= 255) return {d[63], 8'hFF, 23'b0};
    return {d[63], 8'(fe), q[22:0]};
  endfunction

  function automatic bit is_nan32(logic [31:0] b);
    return b[30:23] == 8'hFF && b[22:0] != 0;
  endfunction

  function automatic logic [31:0] mul_single(logic [31:0] a, logic [31:0] b);
    real pr;
    pr = $bitstoreal(widen_single(a)) * $bitstoreal(widen_single(b));
    return narrow_double($realtobits(pr));
  endfunction

  function automatic logic [31:0] predict_power(logic [31:0] base, logic signed [8:0] expo);
    bit          neg;
    int          mag;
    logic [31:0] factor, prod;
    real         rc;
    neg = expo < 0;
    mag = neg ? -int'(expo) : int'(expo);
    if (mag > MAX_EXP) mag = MAX_EXP;
    if (mag == 0) return fipu_pkg::ONE_BITS;
    if (is_nan32(base)) return fipu_pkg::QNAN_BITS;
    if (!neg) factor = base;
    else if (base[30:0] == 0) factor = {base[31], 8'hFF, 23'b0};
    else begin
      rc = 1.0 / $bitstoreal(widen_single(base));
      factor = narrow_double($realtobits(rc));
    end
    prod = fipu_pkg::ONE_BITS;
    for (int i = 0; i < mag; i++) prod = mul_single(prod, factor);
    return is_nan32(prod) ? fipu_pkg::QNAN_BITS : prod;
  endfunction

  function automatic logic [31:0] random_base();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 3) return $urandom;
    if (pick < 8) return {1'($urandom), 8'($urandom_range(124, 130)), 23'($urandom)};
    if (pick == 8) return {1'($urandom), 8'h00, 23'($urandom)};
    return {1'($urandom), 8'($urandom_range(0, 255)), 23'($urandom_range(0, 3))};
  endfunction

  function automatic logic signed [8:0] random_exponent();
    int pick, mag;
    pick = $urandom_range(0, 99);
    if (pick < 2) return 9'sh100;
    if (pick < 5) mag = $urandom_range(200, 255);
    else if (pick < 20) mag = $urandom_range(0, 40);
    else mag = $urandom_range(0, 8);
    return $urandom_range(0, 1) ? -9'(mag) : 9'(mag);
  endfunction

  task automatic add_item(logic [31:0] base, logic signed [8:0] expo);
    power_item_t it;
    it.base = base;
    it.expo = expo;
    pending_items.push_back(it);
  endtask

  initial begin
    add_item(32'h0000_0000, -9'sd1);
    add_item(32'h8000_0000, -9'sd3);
    add_item(32'h8000_0000, 9'sd3);
    add_item(32'h7FC0_1234, 9'sd0);
    add_item(32'hFF80_0001, 9'sd5);
    add_item(32'h7F80_0000, -9'sd2);
    add_item(32'hFF80_0000, 9'sd3);
    add_item(32'h0000_0001, 9'sd1);
    add_item(32'h0000_0001, -9'sd1);
    add_item(32'h007F_FFFF, 9'sd2);
    add_item(32'h0080_0000, -9'sd1);
    add_item(32'h7F7F_FFFF, 9'sd2);
    add_item(32'h7F7F_FFFF, -9'sd1);
    add_item(32'h4000_0000, 9'sd127);
    add_item(32'h4000_0000, 9'sd128);
    add_item(32'h3F00_0000, 9'sd255);
    add_item(32'h3FC0_0000, -9'sd255);
    add_item(32'h3F80_0000, 9'sh100);
    add_item(32'hBF80_0000, 9'sd255);
    add_item(32'h3F80_0001, 9'sh100);
    add_item(32'h4040_0000, -9'sd7);
    add_item(32'hFFFF_FFFF, 9'sd0);
    add_item(32'h7FFF_FFFF, -9'sd1);
    for (int i = 0; i < RAND_ITEMS; i++) add_item(random_base(), random_exponent());
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    wait (pending_items.size() == 0 && !in_valid);
    wait (power_expected.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0 && power_expected.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  always @(posedge clk) begin
    took_in <= in_valid && in_ready && !rst;
    took_out <= out_valid && out_ready && !rst;
    if (!rst && in_valid && in_ready) power_expected.push_back(predict_power(base_bits, exponent));
    if (!rst && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (power_expected.size() == 0) begin
        $display("%0t: unexpected result actual %h", $time, power_bits);
        errors <= errors + 1;
      end else if (power_expected[0] !== power_bits) begin
        $display("%0t: power_bits expected %h actual %h", $time, power_expected[0], power_bits);
        errors <= errors + 1;
        void'(power_expected.pop_front());
      end else begin
        void'(power_expected.pop_front());
      end
    end
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(negedge clk) begin
    power_item_t it;
    if (!rst && (!in_valid || took_in)) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        base_bits <= it.base;
        exponent <= it.expo;
        in_valid <= 1'b1;
        items_sent <= items_sent + 1;
        send_gap <= ((items_sent / 300) % 3 == 1) ? 0 : $urandom_range(0, 14);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (took_out && !long_hold_done && results_seen >= 40) begin
      long_hold_done <= 1'b1;
      out_ready <= 1'b0;
      recv_stall <= LONG_HOLD;
    end else if (took_out) begin
      recv_stall <= ((results_seen / 250) % 3 == 2) ? 0 : $urandom_range(0, 14);
      out_ready <= 1'b0;
    end else if (recv_stall > 0) begin
      out_ready <= 1'b0;
      recv_stall <= recv_stall - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end
endmodule
